[rtl/lmsr_pkg.sv]
// ----------------------------------------------------------------------------
// lmsr_pkg
// Shared types and constants of the LED matrix scan refresh core.
// ----------------------------------------------------------------------------
package lmsr_pkg;

	localparam int ColW    = 7;
	localparam int RowW    = 6;
	localparam int ScanW   = 4;
	localparam int LvlCfgW = 5;
	localparam int LvlW    = 4;
	localparam int RowSelW = 3;
	localparam int PixW    = 12;
	localparam int ColorW  = 16;
	localparam int ColIdxW = 6;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_COLUMNS      = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_ROWS         = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SCAN_ROWS    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_COLOR_LEVELS = 2'd3;

	localparam logic [ColW-1:0]    RST_COLUMNS      = 7'd64;
	localparam logic [RowW-1:0]    RST_ROWS         = 6'd16;
	localparam logic [ScanW-1:0]   RST_SCAN_ROWS    = 4'd8;
	localparam logic [LvlCfgW-1:0] RST_COLOR_LEVELS = 5'd16;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UP_BASE,
		ST_DN_BASE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [ColW-1:0]    columns;
		logic [RowW-1:0]    rows;
		logic [ScanW-1:0]   scan_rows;
		logic [LvlCfgW-1:0] color_levels;
	} cfg_t;

	// one column read issued by the sequencer
	typedef struct packed {
		logic               valid;
		logic [ColW-1:0]    col;
		logic [LvlW-1:0]    level;
		logic [RowSelW-1:0] row;
	} scan_t;

	function automatic logic [PixW-1:0] pack_pixel(input logic [ColorW-1:0] c);
		return {c[15:12], c[9:6], c[3:0]};
	endfunction

endpackage

[rtl/lmsr_ram.sv]
// ----------------------------------------------------------------------------
// lmsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lmsr_ram #(
	parameter int Width = 12,
	parameter int Depth = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/lmsr_cfg.sv]
// ----------------------------------------------------------------------------
// lmsr_cfg
// Configuration registers; presents columns and rows clamped to the panel limits.
// ----------------------------------------------------------------------------
module lmsr_cfg import lmsr_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ColW-1:0]    cfg_data,
	output cfg_t               cfg
);

	logic [ColW-1:0]    columns_q;
	logic [RowW-1:0]    rows_q;
	logic [ScanW-1:0]   scan_rows_q;
	logic [LvlCfgW-1:0] color_levels_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q      <= RST_COLUMNS;
			rows_q         <= RST_ROWS;
			scan_rows_q    <= RST_SCAN_ROWS;
			color_levels_q <= RST_COLOR_LEVELS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COLUMNS:      columns_q      <= cfg_data;
				REG_ROWS:         rows_q         <= cfg_data[RowW-1:0];
				REG_SCAN_ROWS:    scan_rows_q    <= cfg_data[ScanW-1:0];
				REG_COLOR_LEVELS: color_levels_q <= cfg_data[LvlCfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.columns      = (int'(columns_q) > MAX_COLUMNS) ? ColW'(MAX_COLUMNS) : columns_q;
		cfg.rows         = (int'(rows_q) > MAX_ROWS) ? RowW'(MAX_ROWS) : rows_q;
		cfg.scan_rows    = scan_rows_q;
		cfg.color_levels = color_levels_q;
	end

endmodule

[rtl/lmsr_ctrl.sv]
// ----------------------------------------------------------------------------
// lmsr_ctrl
// Scan sequencer: store clearing pass, row base computation by repeated
// modular add of the row pitch, and column read issue.
// ----------------------------------------------------------------------------
module lmsr_ctrl import lmsr_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     tick,
	input  cfg_t                                     cfg,
	output logic                                     busy,
	output logic                                     clr_en,
	output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]  clr_addr,
	output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]  up_addr,
	output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]  dn_addr,
	output scan_t                                    scan
);

	localparam int Depth = MAX_COLUMNS * MAX_ROWS;
	localparam int AddrW = $clog2(Depth);
	localparam logic [AddrW:0]   DepthC = (AddrW+1)'(Depth);
	localparam logic [AddrW-1:0] LastA  = AddrW'(Depth - 1);

	state_t state_q, state_d;

	logic [AddrW-1:0]   acc_q;
	logic [AddrW-1:0]   up_base_q;
	logic [AddrW-1:0]   dn_base_q;
	logic [AddrW-1:0]   clr_q;
	logic [ScanW-1:0]   cnt_q;
	logic [ColW-1:0]    col_q;
	logic [LvlW-1:0]    level_q;
	logic [RowSelW-1:0] row_q;

	logic [AddrW-1:0]   pitch;
	logic [AddrW-1:0]   acc_step;
	logic [LvlCfgW-1:0] lvl_inc;
	logic [ScanW-1:0]   row_inc;
	logic               advance;

	// a + b modulo the store depth, both operands below the depth
	function automatic logic [AddrW-1:0] add_mod(input logic [AddrW-1:0] a,
			input logic [AddrW-1:0] b);
		logic [AddrW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DepthC) begin
			s = s - DepthC;
		end
		return s[AddrW-1:0];
	endfunction

	assign pitch    = AddrW'(cfg.columns);
	assign acc_step = add_mod(acc_q, pitch);
	assign up_addr  = add_mod(up_base_q, AddrW'(col_q));
	assign dn_addr  = add_mod(dn_base_q, AddrW'(col_q));
	assign clr_addr = clr_q;
	assign lvl_inc  = {1'b0, level_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = 1'b1;
		clr_en     = 1'b0;
		advance    = 1'b0;
		scan.valid = 1'b0;
		scan.col   = col_q;
		scan.level = level_q;
		scan.row   = row_q;
		unique case (state_q)
			ST_CLEAR: begin
				clr_en = 1'b1;
				if (clr_q == LastA) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (tick) begin
					state_d = ST_UP_BASE;
				end
			end
			ST_UP_BASE: begin
				if (cnt_q == '0) begin
					state_d = ST_DN_BASE;
				end
			end
			ST_DN_BASE: begin
				if (cnt_q == '0) begin
					if (cfg.columns == '0) begin
						advance = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				scan.valid = 1'b1;
				if (col_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				advance = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			level_q <= '0;
			row_q   <= '0;
		end else begin
			if (clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (advance) begin
				if (lvl_inc >= cfg.color_levels || lvl_inc[LvlW]) begin
					level_q <= '0;
					row_q   <= (row_inc >= cfg.scan_rows || row_inc[RowSelW]) ?
						'0 : row_inc[RowSelW-1:0];
				end else begin
					level_q <= lvl_inc[LvlW-1:0];
				end
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				acc_q <= '0;
				cnt_q <= {1'b0, row_q};
			end
			ST_UP_BASE: begin
				if (cnt_q == '0) begin
					up_base_q <= acc_q;
					cnt_q     <= cfg.scan_rows;
				end else begin
					acc_q <= acc_step;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_DN_BASE: begin
				if (cnt_q == '0) begin
					dn_base_q <= acc_q;
					col_q     <= cfg.columns - 1'b1;
				end else begin
					acc_q <= acc_step;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_SCAN: begin
				col_q <= col_q - 1'b1;
			end
			ST_CLEAR, ST_DRAIN: ;
			default: ;
		endcase
	end

endmodule

[rtl/led_matrix_scan_refresh_core.sv]
// ----------------------------------------------------------------------------
// led_matrix_scan_refresh_core
// Split-scan RGB LED matrix refresh: 4-bit per channel frame store, pixel
// writes with clipping, and per-column PWM compare of a row pair per tick.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | beat marked by
//  ----------+-------------------------------------------+--------------------
//  command   | start, busy, action, x_pos, y_pos, color  | start & !busy
//  result    | result_valid, upper_*, lower_*, row_select,| result_valid
//            | column_index, last                        |
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// After reset the frame store is cleared, one entry a cycle, with busy high.
// A tick steps the row bases on the shared modular adder, then issues one
// column read per cycle, then passes a drain state; results trail the
// column reads through the registered store read and the output registers.
// Results cannot be stalled; each beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module led_matrix_scan_refresh_core import lmsr_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic signed [7:0]   x_pos,
	input  logic signed [7:0]   y_pos,
	input  logic [ColorW-1:0]   color,
	output logic                result_valid,
	output logic                upper_red,
	output logic                upper_green,
	output logic                upper_blue,
	output logic                lower_red,
	output logic                lower_green,
	output logic                lower_blue,
	output logic [RowSelW-1:0]  row_select,
	output logic [ColIdxW-1:0]  column_index,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [ColW-1:0]     cfg_data
);

	localparam int Depth = MAX_COLUMNS * MAX_ROWS;
	localparam int AddrW = $clog2(Depth);
	localparam int ProdW = 15;

	cfg_t  cfg;
	scan_t scan;

	logic             clr_en;
	logic [AddrW-1:0] clr_addr;
	logic [AddrW-1:0] up_addr;
	logic [AddrW-1:0] dn_addr;
	logic             tick;
	logic             pix_ok;
	logic [ProdW-1:0] pix_lin;
	logic             we;
	logic [AddrW-1:0] waddr;
	logic [PixW-1:0]  wdata;
	logic [PixW-1:0]  up_pix;
	logic [PixW-1:0]  dn_pix;

	logic               vld_s1;
	logic [ColW-1:0]    col_s1;
	logic [LvlW-1:0]    lvl_s1;
	logic [RowSelW-1:0] row_s1;

	lmsr_cfg #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign tick = start && !busy && (action == ACT_TICK);

	lmsr_ctrl #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.cfg     (cfg),
		.busy    (busy),
		.clr_en  (clr_en),
		.clr_addr(clr_addr),
		.up_addr (up_addr),
		.dn_addr (dn_addr),
		.scan    (scan)
	);

	// pixel write: clip, then x + y * columns (always inside the store)
	assign pix_ok = start && !busy && (action == ACT_WRITE) &&
		!x_pos[7] && !y_pos[7] &&
		(x_pos[6:0] < cfg.columns) && (y_pos[6:0] < {1'b0, cfg.rows});
	assign pix_lin = ProdW'(y_pos[6:0]) * ProdW'(cfg.columns) + ProdW'(x_pos[6:0]);

	assign we    = clr_en || pix_ok;
	assign waddr = clr_en ? clr_addr : AddrW'(pix_lin);
	assign wdata = clr_en ? '0 : pack_pixel(color);

	// two copies of the store so upper and lower rows read in the same cycle
	lmsr_ram #(
		.Width(PixW),
		.Depth(Depth)
	) u_ram_up (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(up_addr),
		.rdata(up_pix)
	);

	lmsr_ram #(
		.Width(PixW),
		.Depth(Depth)
	) u_ram_dn (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(dn_addr),
		.rdata(dn_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			vld_s1       <= scan.valid;
			result_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1       <= scan.col;
		lvl_s1       <= scan.level;
		row_s1       <= scan.row;
		upper_red    <= up_pix[11:8] > lvl_s1;
		upper_green  <= up_pix[7:4] > lvl_s1;
		upper_blue   <= up_pix[3:0] > lvl_s1;
		lower_red    <= dn_pix[11:8] > lvl_s1;
		lower_green  <= dn_pix[7:4] > lvl_s1;
		lower_blue   <= dn_pix[3:0] > lvl_s1;
		row_select   <= ~row_s1;
		column_index <= col_s1[ColIdxW-1:0];
		last         <= (col_s1 == '0);
	end

endmodule

[tb/sv/led_matrix_scan_refresh_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scan_refresh_core_test
// Self-checking bench for the LED matrix scan refresh core: pixel writes with
// clipping and refresh ticks are driven in random bursts under a series of
// panel settings, and every column beat is checked against a frame store
// predictor kept in the scoreboard.
// ----------------------------------------------------------------------------
module led_matrix_scan_refresh_core_test;
	import lmsr_pkg::*;

	localparam int MaxCols      = 64;
	localparam int MaxRows      = 32;
	localparam int StoreDepth   = MaxCols * MaxRows;
	localparam int IdleLimit    = 10000;
	localparam int SettleCycles = 120;
	localparam int TailCycles   = 120;
	localparam int MaxReports   = 100;

	typedef struct packed {
		logic               upper_red;
		logic               upper_green;
		logic               upper_blue;
		logic               lower_red;
		logic               lower_green;
		logic               lower_blue;
		logic [RowSelW-1:0] row_select;
		logic [ColIdxW-1:0] column_index;
		logic               last;
	} scan_beat_t;

	class refresh_scoreboard;
		logic [PixW-1:0]    pixels [StoreDepth];
		logic [LvlW-1:0]    level;
		logic [RowSelW-1:0] scan_row;
		int                 columns, rows, scan_rows, color_levels;
		scan_beat_t         column_beats [$];
		int                 errors, beats, writes, clipped, ticks;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			level        = '0;
			scan_row     = '0;
			columns      = RST_COLUMNS;
			rows         = RST_ROWS;
			scan_rows    = RST_SCAN_ROWS;
			color_levels = RST_COLOR_LEVELS;
			errors       = 0;
			beats        = 0;
			writes       = 0;
			clipped      = 0;
			ticks        = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [ColW-1:0] data);
			case (idx)
				REG_COLUMNS:      columns = data;
				REG_ROWS:         rows = data[RowW-1:0];
				REG_SCAN_ROWS:    scan_rows = data[ScanW-1:0];
				REG_COLOR_LEVELS: color_levels = data[LvlCfgW-1:0];
				default: ;
			endcase
		endfunction

		function void note_command(logic act, logic signed [7:0] x,
				logic signed [7:0] y, logic [ColorW-1:0] c);
			int              cols, height, xs, ys, col, up_base, dn_base, nl, nr;
			logic [PixW-1:0] up, dn;
			scan_beat_t      b;
			cols   = (columns > MaxCols) ? MaxCols : columns;
			height = (rows > MaxRows) ? MaxRows : rows;
			if (act == ACT_WRITE) begin
				writes++;
				xs = x;
				ys = y;
				if (xs >= 0 && ys >= 0 && xs < cols && ys < height)
					pixels[(xs + ys * cols) % StoreDepth] = {c[15:12], c[9:6], c[3:0]};
				else
					clipped++;
				return;
			end
			ticks++;
			up_base = scan_row * cols;
			dn_base = (scan_row + scan_rows) * cols;
			for (int i = cols; i > 0; i--) begin
				col = i - 1;
				up  = pixels[(up_base + col) % StoreDepth];
				dn  = pixels[(dn_base + col) % StoreDepth];
				b.upper_red    = up[11:8] > level;
				b.upper_green  = up[7:4] > level;
				b.upper_blue   = up[3:0] > level;
				b.lower_red    = dn[11:8] > level;
				b.lower_green  = dn[7:4] > level;
				b.lower_blue   = dn[3:0] > level;
				b.row_select   = ~scan_row;
				b.column_index = col[ColIdxW-1:0];
				b.last         = (col == 0);
				column_beats.push_back(b);
			end
			// level wraps at color_levels or past 15; the row then steps
			nl = level + 1;
			if (nl >= color_levels || nl > 15) begin
				nr       = scan_row + 1;
				level    = '0;
				scan_row = (nr >= scan_rows || nr > 7) ? '0 : nr[RowSelW-1:0];
			end else begin
				level = nl[LvlW-1:0];
			end
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, name, want, got);
			end
		endfunction

		function void check_result(scan_beat_t got);
			scan_beat_t want;
			if (column_beats.size() == 0) begin
				errors++;
				if (errors <= MaxReports)
					$display("%0t: unexpected beat, expected none, actual %h", $time, got);
				return;
			end
			want = column_beats.pop_front();
			beats++;
			check_field("upper_red", want.upper_red, got.upper_red);
			check_field("upper_green", want.upper_green, got.upper_green);
			check_field("upper_blue", want.upper_blue, got.upper_blue);
			check_field("lower_red", want.lower_red, got.lower_red);
			check_field("lower_green", want.lower_green, got.lower_green);
			check_field("lower_blue", want.lower_blue, got.lower_blue);
			check_field("row_select", want.row_select, got.row_select);
			check_field("column_index", want.column_index, got.column_index);
			check_field("last", want.last, got.last);
		endfunction

		function int pending();
			return column_beats.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic signed [7:0]   x_pos;
	logic signed [7:0]   y_pos;
	logic [ColorW-1:0]   color;
	logic                result_valid;
	logic                upper_red, upper_green, upper_blue;
	logic                lower_red, lower_green, lower_blue;
	logic [RowSelW-1:0]  row_select;
	logic [ColIdxW-1:0]  column_index;
	logic                last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [ColW-1:0]     cfg_data;

	refresh_scoreboard sb = new();
	int                burst_left;

	led_matrix_scan_refresh_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.color        (color),
		.result_valid (result_valid),
		.upper_red    (upper_red),
		.upper_green  (upper_green),
		.upper_blue   (upper_blue),
		.lower_red    (lower_red),
		.lower_green  (lower_green),
		.lower_blue   (lower_blue),
		.row_select   (row_select),
		.column_index (column_index),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({upper_red, upper_green, upper_blue, lower_red, lower_green,
				lower_blue, row_select, column_index, last});
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < IdleLimit) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic idle_for(int n);
		@(negedge clk) start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// sender bursts: random length, random gap, sometimes back to back
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 12));
		end
		burst_left--;
	endtask

	task automatic send_command(logic act, logic signed [7:0] x, logic signed [7:0] y,
			logic [ColorW-1:0] c);
		pace();
		@(negedge clk);
		start  <= 1'b1;
		action <= act;
		x_pos  <= x;
		y_pos  <= y;
		color  <= c;
		do @(posedge clk); while (busy);
		sb.note_command(act, x, y, c);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ColW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// only while idle: drain all beats, then let a tick in flight finish
	task automatic apply_settings(int c, int r, int s, int l, bit junk);
		idle_for(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		write_reg(REG_COLUMNS, 7'(c));
		write_reg(REG_ROWS, junk ? {1'($urandom), 6'(r)} : 7'(r));
		write_reg(REG_SCAN_ROWS, junk ? {3'($urandom), 4'(s)} : 7'(s));
		write_reg(REG_COLOR_LEVELS, junk ? {2'($urandom), 5'(l)} : 7'(l));
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic random_item(int cols, int height);
		int                r;
		logic signed [7:0] x, y;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send_command(ACT_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
		end else if (r < 88 && cols > 0 && height > 0) begin
			x = 8'($urandom_range(0, cols - 1));
			y = 8'($urandom_range(0, height - 1));
			send_command(ACT_WRITE, x, y, 16'($urandom));
		end else begin
			send_command(ACT_WRITE, 8'($urandom), 8'($urandom), 16'($urandom));
		end
	endtask

	task automatic run_phase(int c, int r, int s, int l, bit junk, int n);
		apply_settings(c, r, s, l, junk);
		repeat (n) random_item((c > MaxCols) ? MaxCols : c, (r > MaxRows) ? MaxRows : r);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = ACT_WRITE;
		x_pos      = '0;
		y_pos      = '0;
		color      = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_COLUMNS;
		cfg_data   = '0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 64 columns, 16 rows, 8 scan rows, 16 levels
		send_command(ACT_WRITE, 8'(0), 8'(0), 16'hFFFF);
		send_command(ACT_WRITE, 8'(63), 8'(15), 16'h1041);
		send_command(ACT_WRITE, 8'(63), 8'(0), 16'hF000);
		send_command(ACT_WRITE, 8'(0), 8'(8), 16'h03C0);
		send_command(ACT_WRITE, 8'(1), 8'(8), 16'h000F);
		send_command(ACT_WRITE, 8'(5), 8'(8), 16'h8A28);
		send_command(ACT_TICK, 8'(0), 8'(0), 16'h0000);
		// clipped writes: each edge of the panel and the field extremes
		send_command(ACT_WRITE, 8'(-1), 8'(0), 16'hFFFF);
		send_command(ACT_WRITE, 8'(64), 8'(0), 16'hFFFF);
		send_command(ACT_WRITE, 8'(0), 8'(16), 16'hFFFF);
		send_command(ACT_WRITE, 8'(0), 8'(-1), 16'hFFFF);
		send_command(ACT_WRITE, 8'(-128), 8'(-128), 16'hFFFF);
		send_command(ACT_WRITE, 8'(127), 8'(127), 16'hFFFF);
		send_command(ACT_TICK, 8'(-1), 8'(-1), 16'hFFFF);
		send_command(ACT_WRITE, 8'(2), 8'(0), 16'h7D47);
		send_command(ACT_WRITE, 8'(2), 8'(8), 16'hF3CF);
		repeat (6) send_command(ACT_TICK, 8'(0), 8'(0), 16'h0000);

		run_phase(8, 32, 4, 3, 1'b0, 60);
		// oversized columns and rows; scan row steps on every tick and wraps past 7
		run_phase(127, 63, 15, 1, 1'b0, 50);
		// zero width: nothing stored, no beats, ticks still complete
		run_phase(0, 0, 0, 0, 1'b0, 12);
		run_phase(1, 1, 1, 1, 1'b0, 30);
		run_phase(64, 16, 8, 31, 1'b0, 60);
		repeat (3)
			run_phase($urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(1, 8),
				$urandom_range(1, 16), 1'b1, 60);

		idle_for(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		$display("Covered %0d writes (%0d clipped), %0d ticks, %0d column beats checked.",
			sb.writes, sb.clipped, sb.ticks, sb.beats);
		$display("Settings swept: reset, zero and oversized panel, minimum and random sizes.");
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/lmsr_pkg.sv
rtl/lmsr_ram.sv
rtl/lmsr_cfg.sv
rtl/lmsr_ctrl.sv
rtl/led_matrix_scan_refresh_core.sv
tb/sv/led_matrix_scan_refresh_core_test.sv
